// ===== src/pta_pkg.sv =====
// Package for the peer table with aging: command and status codes, register
// indexes, and the structs passed between the controller and the table cells.
// No dependencies; the cell, the top level and the testbench import it.
package pta_pkg;

  // Widest slot index and count that the table can need (up to 64 entries).
  localparam int SLOT_MAX_W = 6;
  localparam int CNT_MAX_W  = 7;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_A_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_A_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_B_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_B_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT   = 3'd4;
  localparam logic [15:0] AGE_LIMIT_RESET = 16'd70;

  // Command codes of an input transaction.
  localparam logic [1:0] CMD_OBSERVE = 2'd0;
  localparam logic [1:0] CMD_SWEEP   = 2'd1;
  localparam logic [1:0] CMD_PICK    = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_REFRESHED = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_FULL      = 3'd2,
    ST_SWEPT     = 3'd3,
    ST_PICKED    = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  // Command fields held by the controller and seen by every cell.
  typedef struct packed {
    logic [1:0]            cmd;
    logic [63:0]           addr_high;
    logic [63:0]           addr_low;
    logic [15:0]           port;
    logic [31:0]           now;
    logic [SLOT_MAX_W-1:0] start;
    logic [15:0]           age_limit;
  } bcast_t;

  // Scan token that moves one cell per cycle and collects the findings.
  typedef struct packed {
    logic                  valid;
    logic                  hit;
    logic [SLOT_MAX_W-1:0] hit_slot;
    logic                  free_found;
    logic [SLOT_MAX_W-1:0] free_slot;
    logic [CNT_MAX_W-1:0]  freed;
    logic                  pick_found;
    logic                  pick_late;
    logic [SLOT_MAX_W-1:0] pick_slot;
    logic [63:0]           pick_addr_high;
    logic [63:0]           pick_addr_low;
    logic [15:0]           pick_port;
  } acc_t;

  // Write-back request from the controller to one cell.
  typedef struct packed {
    logic                  en;
    logic                  refresh;
    logic [SLOT_MAX_W-1:0] slot;
    logic                  perm;
  } wr_t;

endpackage

// ===== src/pta_req_if.sv =====
// Request channel of the peer table: valid/ready handshake and command fields.
// Standalone interface, no dependencies.
interface pta_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] peer_addr_high;
  logic [63:0] peer_addr_low;
  logic [15:0] peer_port;
  logic [31:0] now_seconds;
  logic [3:0]  start_slot;

  modport source (
    output valid, cmd, peer_addr_high, peer_addr_low, peer_port, now_seconds, start_slot,
    input  ready
  );
  modport sink (
    input  valid, cmd, peer_addr_high, peer_addr_low, peer_port, now_seconds, start_slot,
    output ready
  );
endinterface

// ===== src/pta_rsp_if.sv =====
// Result channel of the peer table: valid/ready handshake and result fields.
// Standalone interface, no dependencies.
interface pta_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  slot;
  logic [63:0] entry_addr_high;
  logic [63:0] entry_addr_low;
  logic [15:0] entry_port;
  logic [4:0]  occupied_count;
  logic [4:0]  freed_count;

  modport source (
    output valid, status, slot, entry_addr_high, entry_addr_low, entry_port,
           occupied_count, freed_count,
    input  ready
  );
  modport sink (
    input  valid, status, slot, entry_addr_high, entry_addr_low, entry_port,
           occupied_count, freed_count,
    output ready
  );
endinterface

// ===== src/pta_cell.sv =====
// One slot of the peer table: holds an entry and updates the scan token.
// Depends on pta_pkg.
module pta_cell #(
  parameter int IDX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  pta_pkg::bcast_t bc,
  input  pta_pkg::wr_t    wr,
  input  pta_pkg::acc_t   acc_in,
  output pta_pkg::acc_t   acc_out
);
  import pta_pkg::*;

  localparam logic [SLOT_MAX_W-1:0] MY_SLOT = SLOT_MAX_W'(IDX);

  logic        used;
  logic        perm;
  logic [63:0] addr_high;
  logic [63:0] addr_low;
  logic [15:0] port;
  logic [31:0] seen;

  logic        here;
  logic        match;
  logic        expire;
  logic        late;
  logic        take_pick;
  logic        wr_here;
  logic [31:0] idle;
  acc_t        acc_next;

  // Local decisions for the token passing through this cell.
  assign here      = acc_in.valid;
  assign match     = used && (addr_high == bc.addr_high) && (addr_low == bc.addr_low);
  assign idle      = bc.now - seen;
  assign expire    = used && !perm && (idle > {16'd0, bc.age_limit});
  assign late      = (MY_SLOT >= bc.start);
  assign take_pick = used && (!acc_in.pick_found || (!acc_in.pick_late && late));
  assign wr_here   = wr.en && (wr.slot == MY_SLOT);

  // Fold this entry into the token according to the command.
  always_comb begin
    acc_next = acc_in;
    case (bc.cmd)
      CMD_OBSERVE: begin
        if (match && !acc_in.hit) begin
          acc_next.hit      = 1'b1;
          acc_next.hit_slot = MY_SLOT;
        end
        if (!used && !acc_in.free_found) begin
          acc_next.free_found = 1'b1;
          acc_next.free_slot  = MY_SLOT;
        end
      end
      CMD_SWEEP: begin
        if (expire) begin
          acc_next.freed = acc_in.freed + 1'b1;
        end
      end
      CMD_PICK: begin
        // A used entry at or after the start slot beats any earlier one below the start slot.
        if (take_pick) begin
          acc_next.pick_found     = 1'b1;
          acc_next.pick_late      = late;
          acc_next.pick_slot      = MY_SLOT;
          acc_next.pick_addr_high = addr_high;
          acc_next.pick_addr_low  = addr_low;
          acc_next.pick_port      = port;
        end
      end
      default: ;
    endcase
  end

  // Token register towards the next cell; the valid bit follows the input token.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_out.valid <= 1'b0;
    end else begin
      acc_out <= acc_next;
    end
  end

  // Slot flags: set on insertion, cleared when the sweep expires the entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
      perm <= 1'b0;
    end else if (wr_here) begin
      if (!wr.refresh) begin
        used <= 1'b1;
        perm <= wr.perm;
      end
    end else if (here && (bc.cmd == CMD_SWEEP) && expire) begin
      used <= 1'b0;
      perm <= 1'b0;
    end
  end

  // Entry payload: the whole entry on insertion, only the time on refresh.
  always_ff @(posedge clk) begin
    if (wr_here) begin
      seen <= bc.now;
      if (!wr.refresh) begin
        addr_high <= bc.addr_high;
        addr_low  <= bc.addr_low;
        port      <= bc.port;
      end
    end
  end

endmodule

// ===== src/peer_table_with_aging.sv =====
// Peer table with aging: controller, configuration registers and cell chain.
// Depends on pta_pkg, pta_req_if, pta_rsp_if and pta_cell.
//
// Usage: commands arrive on the req channel (observe, sweep, pick) and each
// one, except the undefined code 3, yields exactly one transaction on the rsp
// channel. Code 3 is accepted and dropped without a result.
// Configuration goes through cfg_we/cfg_index/cfg_data, one register per cycle;
// the user must write only while the block is idle; the block does not enforce it.
// Operation: an accepted command sends a scan token down the row of ENTRIES
// cells, one cell per cycle; the finished token is registered in acc_q and
// its result is then loaded into the output register. The block takes one
// command at a time and accepts no new command until the result of the last
// one has been loaded into the output register.
// The result sits in an output register: a new command can be accepted while
// the previous result waits. If the receiver stalls, the next finished result
// is held inside until the output register frees up.
// Reset (synchronous, rst high) empties the table, clears the bootstrap
// addresses, sets the age limit to 70 and leaves both channels idle.
module peer_table_with_aging #(
  parameter int ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pta_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pta_pkg::CFG_DATA_W-1:0]   cfg_data,
  pta_req_if.sink                          req,
  pta_rsp_if.source                        rsp
);
  import pta_pkg::*;

  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t             state;
  logic               launch;
  bcast_t             bc;
  acc_t               acc_q;
  acc_t               head;
  acc_t               chain [ENTRIES+1];
  logic [CNT_W-1:0]   occ;

  logic [63:0]        boot_a_high;
  logic [63:0]        boot_a_low;
  logic [63:0]        boot_b_high;
  logic [63:0]        boot_b_low;
  logic [15:0]        age_limit;

  logic               rsp_valid;
  status_t            rsp_status;
  logic [3:0]         rsp_slot;
  logic [63:0]        rsp_addr_high;
  logic [63:0]        rsp_addr_low;
  logic [15:0]        rsp_port;
  logic [4:0]         rsp_occ;
  logic [4:0]         rsp_freed;

  logic                  go;
  logic                  boot_hit;
  status_t               res_status;
  logic [SLOT_MAX_W-1:0] res_slot;
  logic [63:0]           res_addr_high;
  logic [63:0]           res_addr_low;
  logic [15:0]           res_port;
  logic [CNT_MAX_W-1:0]  res_freed;
  logic [CNT_W-1:0]      occ_next;
  wr_t                   wr;

  // Reduce the start slot into the table range by repeated subtraction.
  function automatic logic [SLOT_MAX_W-1:0] start_mod(input logic [3:0] s);
    logic [3:0] v;
    v = s;
    for (int k = 0; k < 8; k++) begin
      if (32'(v) >= ENTRIES) begin
        v = v - 4'(ENTRIES);
      end
    end
    return SLOT_MAX_W'(v);
  endfunction

  // Result channel outputs come straight from registers; ready is decoded from the state.
  assign req.ready           = (state == S_IDLE);
  assign rsp.valid           = rsp_valid;
  assign rsp.status          = rsp_status;
  assign rsp.slot            = rsp_slot;
  assign rsp.entry_addr_high = rsp_addr_high;
  assign rsp.entry_addr_low  = rsp_addr_low;
  assign rsp.entry_port      = rsp_port;
  assign rsp.occupied_count  = rsp_occ;
  assign rsp.freed_count     = rsp_freed;

  // The head of the chain carries a fresh token when a command starts.
  always_comb begin
    head       = '0;
    head.valid = launch;
  end

  assign chain[0] = head;

  // Row of table cells.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    pta_cell #(
      .IDX (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .bc      (bc),
      .wr      (wr),
      .acc_in  (chain[g]),
      .acc_out (chain[g+1])
    );
  end

  // Turn the finished token into a result and a write-back request.
  always_comb begin
    go            = !rsp_valid || rsp.ready;
    boot_hit      = ((bc.addr_high == boot_a_high) && (bc.addr_low == boot_a_low)) ||
                    ((bc.addr_high == boot_b_high) && (bc.addr_low == boot_b_low));
    res_status    = ST_FULL;
    res_slot      = '0;
    res_addr_high = '0;
    res_addr_low  = '0;
    res_port      = '0;
    res_freed     = '0;
    occ_next      = occ;
    wr            = '0;
    wr.perm       = boot_hit;
    case (bc.cmd)
      CMD_OBSERVE: begin
        if (acc_q.hit) begin
          res_status = ST_REFRESHED;
          res_slot   = acc_q.hit_slot;
          wr.en      = 1'b1;
          wr.refresh = 1'b1;
          wr.slot    = acc_q.hit_slot;
        end else if (acc_q.free_found) begin
          res_status = ST_INSERTED;
          res_slot   = acc_q.free_slot;
          wr.en      = 1'b1;
          wr.slot    = acc_q.free_slot;
          occ_next   = occ + 1'b1;
        end
      end
      CMD_SWEEP: begin
        res_status = ST_SWEPT;
        res_freed  = acc_q.freed;
        occ_next   = occ - CNT_W'(acc_q.freed);
      end
      CMD_PICK: begin
        if (acc_q.pick_found) begin
          res_status    = ST_PICKED;
          res_slot      = acc_q.pick_slot;
          res_addr_high = acc_q.pick_addr_high;
          res_addr_low  = acc_q.pick_addr_low;
          res_port      = acc_q.pick_port;
        end else begin
          res_status = ST_EMPTY;
        end
      end
      default: ;
    endcase
    wr.en = wr.en && (state == S_DONE) && go;
  end

  // Sequencer, configuration registers and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      launch      <= 1'b0;
      occ         <= '0;
      rsp_valid   <= 1'b0;
      boot_a_high <= '0;
      boot_a_low  <= '0;
      boot_b_high <= '0;
      boot_b_low  <= '0;
      age_limit   <= AGE_LIMIT_RESET;
    end else begin
      // A token starts down the row only for a defined command.
      launch <= (state == S_IDLE) && req.valid &&
                (req.cmd inside {CMD_OBSERVE, CMD_SWEEP, CMD_PICK});

      if (cfg_we) begin
        case (cfg_index)
          CFG_BOOT_A_HIGH: boot_a_high <= cfg_data;
          CFG_BOOT_A_LOW:  boot_a_low  <= cfg_data;
          CFG_BOOT_B_HIGH: boot_b_high <= cfg_data;
          CFG_BOOT_B_LOW:  boot_b_low  <= cfg_data;
          CFG_AGE_LIMIT:   age_limit   <= cfg_data[15:0];
          default: ;
        endcase
      end

      // The result register fills when a scan finishes and empties when taken.
      if ((state == S_DONE) && go) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            bc.cmd       <= req.cmd;
            bc.addr_high <= req.peer_addr_high;
            bc.addr_low  <= req.peer_addr_low;
            bc.port      <= req.peer_port;
            bc.now       <= req.now_seconds;
            bc.start     <= start_mod(req.start_slot);
            bc.age_limit <= age_limit;
            // The undefined command is taken and dropped.
            if (req.cmd inside {CMD_OBSERVE, CMD_SWEEP, CMD_PICK}) begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (chain[ENTRIES].valid) begin
            acc_q <= chain[ENTRIES];
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (go) begin
            rsp_status    <= res_status;
            rsp_slot      <= res_slot[3:0];
            rsp_addr_high <= res_addr_high;
            rsp_addr_low  <= res_addr_low;
            rsp_port      <= res_port;
            rsp_occ       <= 5'(occ_next);
            rsp_freed     <= 5'(res_freed);
            occ           <= occ_next;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The occupancy counter never exceeds the table size.
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(ENTRIES))
    else $error("occupancy count exceeds table size");

  // A token reaches the end of the chain only while a scan is running.
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[ENTRIES].valid |-> state == S_SCAN)
    else $error("scan token left the chain outside a scan");

  // A table write is always accompanied by a result being loaded.
  a_write_has_result: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> rsp_valid)
    else $error("table written without a result");

  // No new token is launched while a command is still in flight.
  a_single_token: assert property (@(posedge clk) disable iff (rst)
    launch |-> (state == S_SCAN) && !chain[ENTRIES].valid)
    else $error("second scan token launched");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the peer table with aging: a directed table and random phases
// of observe, sweep, pick and undefined commands, checked against hand-written results or an in-bench table predictor.
// Depends on pta_pkg, pta_req_if, pta_rsp_if and peer_table_with_aging.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pta_pkg::*;

  localparam int ENTRIES          = 16;
  localparam int RESET_CYCLES     = 6;
  localparam int DRAIN_CYCLES     = 2 * (ENTRIES + 3);
  localparam int HOLD_CYCLES      = 300;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int POOL_SIZE        = 24;
  localparam int NUM_PHASES       = 5;
  localparam int ITEMS_PER_PHASE  = 245;
  localparam int STEADY_PHASE     = 1;
  localparam int WRAP_PHASE       = 2;
  localparam int PRESSURE_PHASE   = 3;
  localparam logic [1:0] CMD_UNDEFINED = 2'd3;
  localparam logic [63:0] BOOT_B_HI = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] BOOT_B_LO = 64'hFEDC_BA98_7654_3210;

  // One command and one result, at the widths of the channels.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] ah;
    logic [63:0] al;
    logic [15:0] port;
    logic [31:0] now;
    logic [3:0]  start;
  } peer_cmd_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic [63:0] ah;
    logic [63:0] al;
    logic [15:0] port;
    logic [4:0]  occ;
    logic [4:0]  freed;
  } peer_result_t;

  typedef struct {
    peer_cmd_t    c;
    bit           typed;
    peer_result_t r;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pta_req_if req_ch ();
  pta_rsp_if rsp_ch ();

  peer_table_with_aging #(.ENTRIES(ENTRIES)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #1 clk = ~clk;

  // Shadow copy of the peer table and its registers.
  bit          tbl_used [ENTRIES];
  bit          tbl_perm [ENTRIES];
  logic [63:0] tbl_ah   [ENTRIES];
  logic [63:0] tbl_al   [ENTRIES];
  logic [15:0] tbl_port [ENTRIES];
  logic [31:0] tbl_seen [ENTRIES];
  logic [63:0] boot_a_hi = '0;
  logic [63:0] boot_a_lo = '0;
  logic [63:0] boot_b_hi = '0;
  logic [63:0] boot_b_lo = '0;
  logic [15:0] age_lim = AGE_LIMIT_RESET;

  peer_result_t expected_results [$];
  dir_row_t     dir_rows [$];
  int  mismatches = 0;
  int  results_checked = 0;
  int  settings_count = 0;
  int  cmd_count [4];
  bit  steady = 1'b0;
  bit  hold_request = 1'b0;

  function automatic peer_cmd_t mk_cmd(logic [1:0] cmd, logic [63:0] ah, logic [63:0] al,
                                       logic [15:0] port, logic [31:0] now,
                                       logic [3:0] start);
    return '{cmd, ah, al, port, now, start};
  endfunction

  function automatic peer_result_t mk_res(status_t st, logic [3:0] slot, logic [63:0] ah,
                                          logic [63:0] al, logic [15:0] port,
                                          logic [4:0] occ, logic [4:0] freed);
    return '{st, slot, ah, al, port, occ, freed};
  endfunction

  // Applies one command to the shadow table; returns 0 when no result is due.
  function automatic bit update_peer_table(input peer_cmd_t c, output peer_result_t r);
    int k;
    int freed_now;
    int used_now;
    bit done;
    logic [31:0] idle;
    logic [3:0] s;
    r = '0;
    done = 1'b0;
    freed_now = 0;
    used_now = 0;
    case (c.cmd)
      CMD_OBSERVE: begin
        // A known peer only gets its last-seen time refreshed.
        for (k = 0; k < ENTRIES; k++) begin
          if (!done && tbl_used[k] && tbl_ah[k] == c.ah && tbl_al[k] == c.al) begin
            tbl_seen[k] = c.now;
            r.status = ST_REFRESHED;
            r.slot = 4'(k);
            done = 1'b1;
          end
        end
        // A new peer takes the lowest free slot, or is dropped on a full table.
        for (k = 0; k < ENTRIES; k++) begin
          if (!done && !tbl_used[k]) begin
            tbl_used[k] = 1'b1;
            tbl_perm[k] = (c.ah == boot_a_hi && c.al == boot_a_lo) ||
                          (c.ah == boot_b_hi && c.al == boot_b_lo);
            tbl_ah[k] = c.ah;
            tbl_al[k] = c.al;
            tbl_port[k] = c.port;
            tbl_seen[k] = c.now;
            r.status = ST_INSERTED;
            r.slot = 4'(k);
            done = 1'b1;
          end
        end
        if (!done) r.status = ST_FULL;
      end
      CMD_SWEEP: begin
        // Idle time is a wrapping 32-bit difference.
        for (k = 0; k < ENTRIES; k++) begin
          if (tbl_used[k] && !tbl_perm[k]) begin
            idle = c.now - tbl_seen[k];
            if (idle > 32'(age_lim)) begin
              tbl_used[k] = 1'b0;
              tbl_perm[k] = 1'b0;
              freed_now++;
            end
          end
        end
        r.status = ST_SWEPT;
        r.freed = 5'(freed_now);
      end
      CMD_PICK: begin
        // First used entry at or after the start slot, wrapping round.
        for (k = 0; k < ENTRIES; k++) begin
          s = 4'((c.start + k) % ENTRIES);
          if (!done && tbl_used[s]) begin
            r.status = ST_PICKED;
            r.slot = s;
            r.ah = tbl_ah[s];
            r.al = tbl_al[s];
            r.port = tbl_port[s];
            done = 1'b1;
          end
        end
        if (!done) r.status = ST_EMPTY;
      end
      default: return 1'b0;
    endcase
    for (k = 0; k < ENTRIES; k++) used_now += tbl_used[k];
    r.occ = 5'(used_now);
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t mismatch in %s: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Writes all five registers back to back and updates the shadow copy.
  task automatic load_regs(input logic [63:0] a_hi, a_lo, b_hi, b_lo, age_word);
    logic [CFG_IDX_W-1:0] reg_idx [5];
    logic [63:0] reg_val [5];
    reg_idx = '{CFG_BOOT_A_HIGH, CFG_BOOT_A_LOW, CFG_BOOT_B_HIGH, CFG_BOOT_B_LOW,
                CFG_AGE_LIMIT};
    reg_val = '{a_hi, a_lo, b_hi, b_lo, age_word};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= reg_idx[i];
      cfg_data <= reg_val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    boot_a_hi = a_hi;
    boot_a_lo = a_lo;
    boot_b_hi = b_hi;
    boot_b_lo = b_lo;
    age_lim = age_word[15:0];
    settings_count++;
  endtask

  // Offers one command, waits for its transaction and records the expected result.
  task automatic send_cmd(input peer_cmd_t c, input bit typed = 1'b0,
                          input peer_result_t typed_r = '0);
    peer_result_t r;
    if (!steady && $urandom_range(0, 99) < 8) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2 * ENTRIES)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.cmd <= c.cmd;
    req_ch.peer_addr_high <= c.ah;
    req_ch.peer_addr_low <= c.al;
    req_ch.peer_port <= c.port;
    req_ch.now_seconds <= c.now;
    req_ch.start_slot <= c.start;
    do @(posedge clk); while (!req_ch.ready);
    cmd_count[c.cmd]++;
    if (update_peer_table(c, r)) expected_results.push_back(typed ? typed_r : r);
  endtask

  // Lets every outstanding result arrive, then lets the block settle.
  task automatic drain;
    req_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result checker: every transaction is compared with the oldest expectation.
  peer_result_t want;
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: status %0d slot %0d", $time, rsp_ch.status,
                 rsp_ch.slot);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 64'(want.status), 64'(rsp_ch.status));
        check_field("slot", 64'(want.slot), 64'(rsp_ch.slot));
        check_field("entry_addr_high", want.ah, rsp_ch.entry_addr_high);
        check_field("entry_addr_low", want.al, rsp_ch.entry_addr_low);
        check_field("entry_port", 64'(want.port), 64'(rsp_ch.entry_port));
        check_field("occupied_count", 64'(want.occ), 64'(rsp_ch.occupied_count));
        check_field("freed_count", 64'(want.freed), 64'(rsp_ch.freed_count));
        results_checked++;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 8);
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_we || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    peer_cmd_t c;
    logic [63:0] pool_hi [POOL_SIZE];
    logic [63:0] pool_lo [POOL_SIZE];
    logic [63:0] b_hi;
    logic [63:0] b_lo;
    logic [63:0] age_word;
    logic [31:0] clock_now;
    int a_idx;
    int b_idx;
    int roll;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_OBSERVE;
    req_ch.peer_addr_high = '0;
    req_ch.peer_addr_low = '0;
    req_ch.peer_port = '0;
    req_ch.now_seconds = '0;
    req_ch.start_slot = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    load_regs('1, '1, BOOT_B_HI, BOOT_B_LO, 64'(AGE_LIMIT_RESET));

    // Directed table: empty table, permanent peers, refresh, wrap of pick,
    // undefined command, filling up, full drop and an aging sweep.
    dir_rows.push_back('{mk_cmd(CMD_PICK, '0, '0, '0, '0, 4'd0), 1'b1,
                         mk_res(ST_EMPTY, 4'd0, '0, '0, '0, 5'd0, 5'd0)});
    dir_rows.push_back('{mk_cmd(CMD_SWEEP, '0, '0, '0, '1, 4'd0), 1'b1,
                         mk_res(ST_SWEPT, 4'd0, '0, '0, '0, 5'd0, 5'd0)});
    dir_rows.push_back('{mk_cmd(CMD_OBSERVE, '1, '1, '1, 32'hFFFF_FFF0, 4'd0), 1'b1,
                         mk_res(ST_INSERTED, 4'd0, '0, '0, '0, 5'd1, 5'd0)});
    dir_rows.push_back('{mk_cmd(CMD_OBSERVE, '0, '0, '0, '0, 4'd0), 1'b1,
                         mk_res(ST_INSERTED, 4'd1, '0, '0, '0, 5'd2, 5'd0)});
    dir_rows.push_back('{mk_cmd(CMD_OBSERVE, BOOT_B_HI, BOOT_B_LO, 16'h1234, 32'd5, 4'd0),
                         1'b1, mk_res(ST_INSERTED, 4'd2, '0, '0, '0, 5'd3, 5'd0)});
    dir_rows.push_back('{mk_cmd(CMD_OBSERVE, '0, '0, 16'hABCD, 32'd100, 4'd0), 1'b1,
                         mk_res(ST_REFRESHED, 4'd1, '0, '0, '0, 5'd3, 5'd0)});
    dir_rows.push_back('{mk_cmd(CMD_PICK, '0, '0, '0, '0, 4'd15), 1'b1,
                         mk_res(ST_PICKED, 4'd0, '1, '1, '1, 5'd3, 5'd0)});
    dir_rows.push_back('{mk_cmd(CMD_PICK, '1, '1, '1, '1, 4'd1), 1'b1,
                         mk_res(ST_PICKED, 4'd1, '0, '0, '0, 5'd3, 5'd0)});
    dir_rows.push_back('{mk_cmd(CMD_UNDEFINED, '1, '1, '1, '1, 4'd15), 1'b0, '0});
    for (int k = 0; k < ENTRIES - 3; k++) begin
      dir_rows.push_back('{mk_cmd(CMD_OBSERVE, {32'hA5A5_5A5A, 32'(k)},
                                  {32'(k), 32'h0F0F_F0F0}, 16'(k * 4099),
                                  32'(1000 + k), 4'(k)), 1'b0, '0});
    end
    dir_rows.push_back('{mk_cmd(CMD_OBSERVE, 64'd5, 64'd6, 16'h7777, 32'd1020, 4'd0), 1'b1,
                         mk_res(ST_FULL, 4'd0, '0, '0, '0, 5'd16, 5'd0)});
    dir_rows.push_back('{mk_cmd(CMD_SWEEP, '0, '0, '0, 32'd1100, 4'd0), 1'b0, '0});
    dir_rows.push_back('{mk_cmd(CMD_PICK, '0, '0, '0, '0, 4'd3), 1'b0, '0});
    foreach (dir_rows[i]) send_cmd(dir_rows[i].c, dir_rows[i].typed, dir_rows[i].r);
    drain;

    // Random phases, each with its own registers and a pool of recurring peers.
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int i = 0; i < POOL_SIZE; i++) begin
        pool_hi[i] = {$urandom, $urandom};
        pool_lo[i] = {$urandom, $urandom};
      end
      pool_hi[0] = '0;
      pool_lo[0] = '0;
      pool_hi[1] = '1;
      pool_lo[1] = '1;
      case (p)
        0: age_word = 64'd0;
        1: age_word = 64'hFFFF;
        2: age_word = {$urandom, 16'($urandom), 16'd70};
        3: age_word = 64'($urandom_range(1, 300));
        default: age_word = {$urandom, $urandom};
      endcase
      a_idx = $urandom_range(0, POOL_SIZE - 1);
      b_idx = (p == NUM_PHASES - 1) ? a_idx : $urandom_range(0, POOL_SIZE - 1);
      b_hi = pool_hi[b_idx];
      b_lo = pool_lo[b_idx];
      // In one phase the second bootstrap peer never shows up.
      if (p == PRESSURE_PHASE) begin
        b_hi = {$urandom, $urandom};
        b_lo = {$urandom, $urandom};
      end
      load_regs(pool_hi[a_idx], pool_lo[a_idx], b_hi, b_lo, age_word);
      clock_now = (p == WRAP_PHASE) ? 32'hFFFF_FE00 : $urandom;
      steady = (p == STEADY_PHASE);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == PRESSURE_PHASE && n == 40) hold_request = 1'b1;
        clock_now += $urandom_range(0, 4 + age_lim / 6);
        roll = $urandom_range(0, 99);
        c.cmd = (roll < 55) ? CMD_OBSERVE : (roll < 72) ? CMD_SWEEP :
                (roll < 97) ? CMD_PICK : CMD_UNDEFINED;
        c.ah = {$urandom, $urandom};
        c.al = {$urandom, $urandom};
        if (c.cmd == CMD_OBSERVE && $urandom_range(0, 99) < 85) begin
          a_idx = $urandom_range(0, POOL_SIZE - 1);
          c.ah = pool_hi[a_idx];
          c.al = pool_lo[a_idx];
        end
        c.port = 16'($urandom);
        c.now = ($urandom_range(0, 99) < 5) ? $urandom : clock_now;
        c.start = 4'($urandom);
        send_cmd(c);
      end
      steady = 1'b0;
      drain;
    end

    $display("Covered %0d observe, %0d sweep, %0d pick and %0d undefined commands",
             cmd_count[CMD_OBSERVE], cmd_count[CMD_SWEEP], cmd_count[CMD_PICK],
             cmd_count[CMD_UNDEFINED]);
    $display("over %0d register settings; %0d results checked, %0d mismatches.",
             settings_count, results_checked, mismatches);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
